// File: design/i2c_master_byte_sequencer_defines.svh
// Assertion macros shared by the byte sequencer checker.
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define I2CMS_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define I2CMS_ASSERT(name, prop, msg) \
  `I2CMS_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// File: design/i2cms_pkg.sv
// Types and constants shared by the I2C master byte sequencer modules.
package i2cms_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned DelayW = 18;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitCntW = 4;

  localparam logic [TickW-1:0] UnitTicksRst  = 16'd100;
  localparam logic [TickW-1:0] AckTimeoutRst = 16'd2500;

  // Configuration register indexes.
  localparam logic CfgUnitTicks  = 1'b0;
  localparam logic CfgAckTimeout = 1'b1;

  localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_WAIT_ACK = 3'd4
  } op_e;

  typedef enum logic [14:0] {
    PH_IDLE    = 15'b000000000000001,
    PH_ST_A    = 15'b000000000000010,
    PH_ST_B    = 15'b000000000000100,
    PH_SP_A    = 15'b000000000001000,
    PH_SP_B    = 15'b000000000010000,
    PH_WR_SET  = 15'b000000000100000,
    PH_WR_HIGH = 15'b000000001000000,
    PH_WR_LOW  = 15'b000000010000000,
    PH_RD_LOW  = 15'b000000100000000,
    PH_RD_HIGH = 15'b000001000000000,
    PH_AK_LOW  = 15'b000010000000000,
    PH_AK_HIGH = 15'b000100000000000,
    PH_WA_SDA  = 15'b001000000000000,
    PH_WA_SCL  = 15'b010000000000000,
    PH_WA_POLL = 15'b100000000000000
  } phase_e;

  // Delay lengths in units; the code is the shift applied to the unit length.
  typedef enum logic [1:0] {
    UNITS_1 = 2'd0,
    UNITS_2 = 2'd1,
    UNITS_4 = 2'd2
  } units_e;

  typedef struct packed {
    logic   load;
    logic   dec;
    logic   clr;
    units_e units;
  } tmr_ctrl_t;

  typedef struct packed {
    logic             scl_out;
    logic             sda_release;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] rx_byte;
    logic             ack_error;
  } result_t;

endpackage

// File: design/i2cms_timer.sv
// Delay counter for the bus phases, loaded in multiples of the unit length.
module i2cms_timer import i2cms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  tmr_ctrl_t        ctrl_i,
  input  logic [TickW-1:0] unit_ticks_i,
  output logic             expired_o
);

  logic [DelayW-1:0] cnt_q, cnt_d;
  logic [TickW-1:0]  unit_len;
  logic [DelayW-1:0] load_val;

  // A zero unit length behaves as one tick.
  assign unit_len = (unit_ticks_i == '0) ? TickW'(1) : unit_ticks_i;

  always_comb begin
    case (ctrl_i.units)
      UNITS_1: load_val = DelayW'(unit_len);
      UNITS_2: load_val = DelayW'(unit_len) << 1;
      UNITS_4: load_val = DelayW'(unit_len) << 2;
      default: load_val = DelayW'(unit_len);
    endcase
  end

  assign expired_o = (cnt_q <= DelayW'(1));

  always_comb begin
    cnt_d = cnt_q;
    if (step_i) begin
      if (ctrl_i.load) begin
        cnt_d = load_val;
      end else if (ctrl_i.dec) begin
        cnt_d = cnt_q - DelayW'(1);
      end else if (ctrl_i.clr) begin
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: design/i2cms_fsm.sv
// Command sequencer: bus phase, bit and poll counters, shift register and line levels.
module i2cms_fsm import i2cms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             cmd_valid_i,
  input  logic [2:0]       op_i,
  input  logic [ByteW-1:0] tx_byte_i,
  input  logic             send_ack_i,
  input  logic             sda_in_i,
  input  logic [TickW-1:0] ack_timeout_i,
  input  logic             tmr_expired_i,
  output tmr_ctrl_t        tmr_ctrl_o,
  output result_t          result_o
);

  phase_e             phase_q, phase_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [BitCntW-1:0] bit_cnt_inc;
  logic [TickW-1:0]   poll_cnt_q, poll_cnt_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [ByteW-1:0]   rx_q, rx_d;
  logic               ack_choice_q, ack_choice_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               timeout_q, timeout_d;
  logic               done;

  assign bit_cnt_inc = bit_cnt_q + BitCntW'(1);

  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    poll_cnt_d   = poll_cnt_q;
    shift_d      = shift_q;
    rx_d         = rx_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    timeout_d    = timeout_q;
    done         = 1'b0;
    tmr_ctrl_o   = '{load: 1'b0, dec: 1'b0, clr: 1'b0, units: UNITS_1};

    case (phase_q)
      PH_IDLE: begin
        if (cmd_valid_i) begin
          case (op_e'(op_i))
            OP_START: begin
              bit_cnt_d = '0;
              sda_d = 1'b1;
              scl_d = 1'b1;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_4;
              phase_d = PH_ST_A;
            end
            OP_STOP: begin
              bit_cnt_d = '0;
              scl_d = 1'b0;
              sda_d = 1'b0;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_4;
              phase_d = PH_SP_A;
            end
            OP_WRITE: begin
              bit_cnt_d = '0;
              scl_d = 1'b0;
              sda_d = tx_byte_i[ByteW-1];
              shift_d = {tx_byte_i[ByteW-2:0], 1'b0};
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_2;
              phase_d = PH_WR_SET;
            end
            OP_READ: begin
              bit_cnt_d = '0;
              ack_choice_d = send_ack_i;
              shift_d = '0;
              sda_d = 1'b1;
              scl_d = 1'b0;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_2;
              phase_d = PH_RD_LOW;
            end
            OP_WAIT_ACK: begin
              bit_cnt_d = '0;
              timeout_d = 1'b0;
              poll_cnt_d = '0;
              sda_d = 1'b1;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_1;
              phase_d = PH_WA_SDA;
            end
            default: begin
            end
          endcase
        end
      end
      PH_WA_POLL: begin
        if (!sda_in_i) begin
          scl_d = 1'b0;
          phase_d = PH_IDLE;
          done = 1'b1;
        end else if (poll_cnt_q >= ack_timeout_i) begin
          // No acknowledge in time: flag it and release the bus with a stop.
          timeout_d = 1'b1;
          scl_d = 1'b0;
          sda_d = 1'b0;
          tmr_ctrl_o.load = 1'b1;
          tmr_ctrl_o.units = UNITS_4;
          phase_d = PH_SP_A;
        end else begin
          poll_cnt_d = poll_cnt_q + TickW'(1);
        end
      end
      default: begin
        if (!tmr_expired_i) begin
          tmr_ctrl_o.dec = 1'b1;
        end else begin
          tmr_ctrl_o.clr = 1'b1;
          case (phase_q)
            PH_ST_A: begin
              sda_d = 1'b0;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_4;
              phase_d = PH_ST_B;
            end
            PH_ST_B: begin
              scl_d = 1'b0;
              phase_d = PH_IDLE;
              done = 1'b1;
            end
            PH_SP_A: begin
              scl_d = 1'b1;
              sda_d = 1'b1;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_4;
              phase_d = PH_SP_B;
            end
            PH_SP_B: begin
              phase_d = PH_IDLE;
              done = 1'b1;
            end
            PH_WR_SET: begin
              scl_d = 1'b1;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_2;
              phase_d = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
              scl_d = 1'b0;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_2;
              phase_d = PH_WR_LOW;
            end
            PH_WR_LOW: begin
              bit_cnt_d = bit_cnt_inc;
              if (bit_cnt_inc >= BitsPerByte) begin
                phase_d = PH_IDLE;
                done = 1'b1;
              end else begin
                sda_d = shift_q[ByteW-1];
                shift_d = {shift_q[ByteW-2:0], 1'b0};
                tmr_ctrl_o.load = 1'b1;
                tmr_ctrl_o.units = UNITS_2;
                phase_d = PH_WR_SET;
              end
            end
            PH_RD_LOW: begin
              // The data bit is taken on the tick that raises SCL.
              scl_d = 1'b1;
              shift_d = {shift_q[ByteW-2:0], sda_in_i};
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_1;
              phase_d = PH_RD_HIGH;
            end
            PH_RD_HIGH: begin
              bit_cnt_d = bit_cnt_inc;
              scl_d = 1'b0;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_2;
              if (bit_cnt_inc >= BitsPerByte) begin
                sda_d = !ack_choice_q;
                phase_d = PH_AK_LOW;
              end else begin
                phase_d = PH_RD_LOW;
              end
            end
            PH_AK_LOW: begin
              scl_d = 1'b1;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_2;
              phase_d = PH_AK_HIGH;
            end
            PH_AK_HIGH: begin
              scl_d = 1'b0;
              rx_d = shift_q;
              phase_d = PH_IDLE;
              done = 1'b1;
            end
            PH_WA_SDA: begin
              scl_d = 1'b1;
              tmr_ctrl_o.load = 1'b1;
              tmr_ctrl_o.units = UNITS_1;
              phase_d = PH_WA_SCL;
            end
            PH_WA_SCL: begin
              phase_d = PH_WA_POLL;
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  assign result_o = '{
    scl_out:     scl_d,
    sda_release: sda_d,
    busy_res:    (phase_d != PH_IDLE),
    done_res:    done,
    rx_byte:     rx_d,
    ack_error:   timeout_d
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_cnt_q    <= '0;
      poll_cnt_q   <= '0;
      shift_q      <= '0;
      rx_q         <= '0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      timeout_q    <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      poll_cnt_q   <= poll_cnt_d;
      shift_q      <= shift_d;
      rx_q         <= rx_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      timeout_q    <= timeout_d;
    end
  end

endmodule

// File: design/i2c_master_byte_sequencer.sv
// Top level of the I2C master byte sequencer: handshakes, settings and result register.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o  cmd_valid, op, tx_byte, send_ack, sda_in
//   out      source     out_valid_o/out_ready_i scl_out, sda_release, busy_res, done_res,
//                                              rx_byte, ack_error
//   cfg      sink       cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One tick is taken per cycle unless the output stalls; its result is in the output
// register the next cycle. The single output register is refilled in the cycle it is
// drained, so a consumer that keeps out_ready_i high sees one result per cycle while ticks keep arriving.
// A stalled output holds in_ready_o low until the waiting result is taken.
// Reset sets unit_ticks to 100, ack_timeout to 2500 and both bus lines released.
module i2c_master_byte_sequencer import i2cms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [TickW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_valid_i,
  input  logic [2:0]       op_i,
  input  logic [ByteW-1:0] tx_byte_i,
  input  logic             send_ack_i,
  input  logic             sda_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             scl_out_o,
  output logic             sda_release_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [ByteW-1:0] rx_byte_o,
  output logic             ack_error_o
);

  logic [TickW-1:0] unit_ticks_q;
  logic [TickW-1:0] ack_timeout_q;
  logic             out_valid_q;
  result_t          res_q;
  result_t          res_d;
  logic             step;
  logic             tmr_expired;
  tmr_ctrl_t        tmr_ctrl;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q  <= UnitTicksRst;
      ack_timeout_q <= AckTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgUnitTicks:  unit_ticks_q  <= cfg_wdata_i;
        CfgAckTimeout: ack_timeout_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  i2cms_timer u_timer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .ctrl_i       (tmr_ctrl),
    .unit_ticks_i (unit_ticks_q),
    .expired_o    (tmr_expired)
  );

  i2cms_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .cmd_valid_i   (cmd_valid_i),
    .op_i          (op_i),
    .tx_byte_i     (tx_byte_i),
    .send_ack_i    (send_ack_i),
    .sda_in_i      (sda_in_i),
    .ack_timeout_i (ack_timeout_q),
    .tmr_expired_i (tmr_expired),
    .tmr_ctrl_o    (tmr_ctrl),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_out_o     = res_q.scl_out;
  assign sda_release_o = res_q.sda_release;
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign rx_byte_o     = res_q.rx_byte;
  assign ack_error_o   = res_q.ack_error;

endmodule

// File: design/i2cms_checker.sv
// Port-level checker for the I2C master byte sequencer, bound to the top level.
`include "i2c_master_byte_sequencer_defines.svh"

module i2cms_checker import i2cms_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             scl_out_o,
  input logic             sda_release_o,
  input logic             busy_res_o,
  input logic             done_res_o,
  input logic [ByteW-1:0] rx_byte_o,
  input logic             ack_error_o
);

  logic             out_stall;
  logic [ByteW+4:0] res_bits;

  assign out_stall = out_valid_o && !out_ready_i;
  assign res_bits  = {scl_out_o, sda_release_o, busy_res_o, done_res_o, rx_byte_o, ack_error_o};

  // A result that is not taken stays offered with the same bits.
  `I2CMS_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(res_bits), "held result changed")

  // Every accepted tick produces a result in the next cycle.
  `I2CMS_ASSERT(a_in_to_out, in_valid_i && in_ready_o |=> out_valid_o, "accepted tick gave no result")

  // An empty output stage never blocks the input.
  `I2CMS_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input blocked with empty output")

  // A finished command always leaves the sequencer idle.
  `I2CMS_ASSERT(a_done_idle, out_valid_o && done_res_o |-> !busy_res_o, "done pulse while still busy")

endmodule

bind i2c_master_byte_sequencer i2cms_checker u_i2cms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .scl_out_o     (scl_out_o),
  .sda_release_o (sda_release_o),
  .busy_res_o    (busy_res_o),
  .done_res_o    (done_res_o),
  .rx_byte_o     (rx_byte_o),
  .ack_error_o   (ack_error_o)
);

// File: test/i2c_master_byte_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master byte sequencer, one bus tick per transfer.
module i2c_master_byte_sequencer_test;
  import i2cms_pkg::*;

  localparam logic [2:0] OpRsvd5 = 3'd5;
  localparam logic [2:0] OpRsvd6 = 3'd6;
  localparam logic [2:0] OpRsvd7 = 3'd7;
  localparam int NumRows = 27;
  localparam int NumSettings = 8;
  localparam int RandomTicks = 800;
  localparam int HoldCycles = 150;

  localparam result_t IdleReleased = '{scl_out: 1'b1, sda_release: 1'b1, default: '0};
  localparam result_t IdleBusLow = '0;

  typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_COIN, SDA_MOSTLY_HIGH} sda_drive_e;
  typedef enum logic [1:0] {ROW_REG, ROW_TICK, ROW_CMD} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic             cv;
    logic [2:0]       op;
    logic [ByteW-1:0] tx;
    logic             ack;
    sda_drive_e       sda;
    logic             reg_idx;
    logic [TickW-1:0] reg_val;
    logic             typed;
    result_t          want;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = 1'b0;
  logic [TickW-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready_o;
  logic             cmd_valid = 1'b0;
  logic [2:0]       op = '0;
  logic [ByteW-1:0] tx_byte = '0;
  logic             send_ack = 1'b0;
  logic             sda_in = 1'b1;
  logic             out_valid_o;
  logic             out_ready = 1'b0;
  logic             scl_out_o;
  logic             sda_release_o;
  logic             busy_res_o;
  logic             done_res_o;
  logic [ByteW-1:0] rx_byte_o;
  logic             ack_error_o;

  // Sequencer state as the predictor tracks it.
  phase_e             seq_phase;
  logic [DelayW-1:0]  delay_left;
  logic [BitCntW-1:0] bit_idx;
  logic [TickW-1:0]   poll_cnt;
  logic [ByteW-1:0]   shreg;
  logic [ByteW-1:0]   rx_hold;
  logic               ack_sel;
  logic               scl_q;
  logic               sda_q;
  logic               timed_out;
  logic [TickW-1:0]   cfg_unit;
  logic [TickW-1:0]   cfg_timeout;

  result_t predicted_bus_q[$];
  int      fault_count = 0;
  int      ticks_sent = 0;
  logic    use_typed = 1'b0;
  result_t typed_res = '0;
  logic    steady = 1'b0;
  logic    hold_req = 1'b0;

  stim_row_t plan [NumRows];
  int unsigned unit_set [NumSettings] = '{1, 2, 1, 3, 0, 1, 4, 1};
  int unsigned tmo_set [NumSettings] = '{2, 4, 1, 0, 6, 65535, 10, 5};

  i2c_master_byte_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .cmd_valid_i  (cmd_valid),
    .op_i         (op),
    .tx_byte_i    (tx_byte),
    .send_ack_i   (send_ack),
    .sda_in_i     (sda_in),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .scl_out_o    (scl_out_o),
    .sda_release_o(sda_release_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .rx_byte_o    (rx_byte_o),
    .ack_error_o  (ack_error_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic sda_for(sda_drive_e drive);
    case (drive)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      SDA_COIN: return 1'(($urandom_range(1)));
      default:  return ($urandom_range(7) != 0);
    endcase
  endfunction

  task automatic arm_delay(input int unsigned units, input phase_e next);
    logic [DelayW-1:0] unit_len;
    unit_len = (cfg_unit == '0) ? DelayW'(1) : DelayW'(cfg_unit);
    delay_left = DelayW'(units * unit_len);
    if (delay_left == '0) delay_left = DelayW'(1);
    seq_phase = next;
  endtask

  task automatic shift_out();
    sda_q = shreg[ByteW-1];
    shreg = {shreg[ByteW-2:0], 1'b0};
  endtask

  task automatic start_stop_seq();
    scl_q = 1'b0;
    sda_q = 1'b0;
    arm_delay(4, PH_SP_A);
  endtask

  task automatic reset_sequencer();
    cfg_unit = UnitTicksRst;
    cfg_timeout = AckTimeoutRst;
    seq_phase = PH_IDLE;
    delay_left = '0;
    bit_idx = '0;
    poll_cnt = '0;
    shreg = '0;
    rx_hold = '0;
    ack_sel = 1'b0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    timed_out = 1'b0;
  endtask

  // Advances the predicted sequencer by one tick and returns the bus levels after it.
  task automatic sequencer_tick(input logic cv, input logic [2:0] cmd, input logic [ByteW-1:0] txb,
                                input logic ack, input logic sda, output result_t r);
    logic finished;
    finished = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (cv && cmd <= OP_WAIT_ACK) begin
        bit_idx = '0;
        case (cmd)
          OP_START: begin
            sda_q = 1'b1;
            scl_q = 1'b1;
            arm_delay(4, PH_ST_A);
          end
          OP_STOP: start_stop_seq();
          OP_WRITE: begin
            scl_q = 1'b0;
            shreg = txb;
            shift_out();
            arm_delay(2, PH_WR_SET);
          end
          OP_READ: begin
            ack_sel = ack;
            shreg = '0;
            sda_q = 1'b1;
            scl_q = 1'b0;
            arm_delay(2, PH_RD_LOW);
          end
          default: begin
            timed_out = 1'b0;
            poll_cnt = '0;
            sda_q = 1'b1;
            arm_delay(1, PH_WA_SDA);
          end
        endcase
      end
    end else if (seq_phase == PH_WA_POLL) begin
      if (!sda) begin
        scl_q = 1'b0;
        seq_phase = PH_IDLE;
        finished = 1'b1;
      end else if (poll_cnt >= cfg_timeout) begin
        timed_out = 1'b1;
        start_stop_seq();
      end else begin
        poll_cnt = poll_cnt + TickW'(1);
      end
    end else if (delay_left > DelayW'(1)) begin
      delay_left = delay_left - DelayW'(1);
    end else begin
      delay_left = '0;
      case (seq_phase)
        PH_ST_A: begin
          sda_q = 1'b0;
          arm_delay(4, PH_ST_B);
        end
        PH_ST_B: begin
          scl_q = 1'b0;
          seq_phase = PH_IDLE;
          finished = 1'b1;
        end
        PH_SP_A: begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          arm_delay(4, PH_SP_B);
        end
        PH_SP_B: begin
          seq_phase = PH_IDLE;
          finished = 1'b1;
        end
        PH_WR_SET: begin
          scl_q = 1'b1;
          arm_delay(2, PH_WR_HIGH);
        end
        PH_WR_HIGH: begin
          scl_q = 1'b0;
          arm_delay(2, PH_WR_LOW);
        end
        PH_WR_LOW: begin
          bit_idx = bit_idx + BitCntW'(1);
          if (bit_idx >= BitsPerByte) begin
            seq_phase = PH_IDLE;
            finished = 1'b1;
          end else begin
            shift_out();
            arm_delay(2, PH_WR_SET);
          end
        end
        PH_RD_LOW: begin
          scl_q = 1'b1;
          shreg = {shreg[ByteW-2:0], sda};
          arm_delay(1, PH_RD_HIGH);
        end
        PH_RD_HIGH: begin
          bit_idx = bit_idx + BitCntW'(1);
          scl_q = 1'b0;
          if (bit_idx >= BitsPerByte) begin
            sda_q = !ack_sel;
            arm_delay(2, PH_AK_LOW);
          end else begin
            arm_delay(2, PH_RD_LOW);
          end
        end
        PH_AK_LOW: begin
          scl_q = 1'b1;
          arm_delay(2, PH_AK_HIGH);
        end
        PH_AK_HIGH: begin
          scl_q = 1'b0;
          rx_hold = shreg;
          seq_phase = PH_IDLE;
          finished = 1'b1;
        end
        PH_WA_SDA: begin
          scl_q = 1'b1;
          arm_delay(1, PH_WA_SCL);
        end
        PH_WA_SCL: seq_phase = PH_WA_POLL;
        default: seq_phase = PH_IDLE;
      endcase
    end
    r.scl_out = scl_q;
    r.sda_release = sda_q;
    r.busy_res = (seq_phase != PH_IDLE);
    r.done_res = finished;
    r.rx_byte = rx_hold;
    r.ack_error = timed_out;
  endtask

  // Prediction on accepted ticks, comparison on accepted results.
  always @(posedge clk_i) begin
    result_t predicted;
    result_t seen;
    if (rst_ni) begin
      if (in_valid && in_ready_o === 1'b1) begin
        sequencer_tick(cmd_valid, op, tx_byte, send_ack, sda_in, predicted);
        predicted_bus_q.push_back(use_typed ? typed_res : predicted);
      end
      if (out_valid_o === 1'b1 && out_ready) begin
        seen = '{scl_out_o, sda_release_o, busy_res_o, done_res_o, rx_byte_o, ack_error_o};
        if (predicted_bus_q.size() == 0) begin
          if (fault_count < 10) $display("result transfer with nothing expected at %0t", $realtime);
          fault_count++;
        end else begin
          predicted = predicted_bus_q.pop_front();
          if (seen.scl_out !== predicted.scl_out || seen.sda_release !== predicted.sda_release ||
              seen.busy_res !== predicted.busy_res || seen.done_res !== predicted.done_res ||
              seen.rx_byte !== predicted.rx_byte || seen.ack_error !== predicted.ack_error) begin
            if (fault_count < 10) begin
              $display("mismatch at %0t: expected scl=%0b sda=%0b busy=%0b done=%0b rx=%02h err=%0b",
                       $realtime, predicted.scl_out, predicted.sda_release, predicted.busy_res,
                       predicted.done_res, predicted.rx_byte, predicted.ack_error);
              $display("                 got      scl=%0b sda=%0b busy=%0b done=%0b rx=%02h err=%0b",
                       seen.scl_out, seen.sda_release, seen.busy_res, seen.done_res,
                       seen.rx_byte, seen.ack_error);
            end
            fault_count++;
          end
        end
      end
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    int gap;
    stall_left = 0;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_ready = 1'b0;
      end else if (steady) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        gap = pick_gap();
        stall_left = (gap > 0) ? gap - 1 : 0;
        out_ready = (gap == 0);
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge that follows
  // the transfer.
  task automatic send_tick(input logic cv, input logic [2:0] cmd, input logic [ByteW-1:0] txb,
                           input logic ack, input logic sda);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_valid = cv;
    op = cmd;
    tx_byte = txb;
    send_ack = ack;
    sda_in = sda;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    @(negedge clk_i);
    use_typed = 1'b0;
    ticks_sent++;
  endtask

  // Issues one command, then keeps the bus ticking until the sequence ends. The extra
  // ticks sometimes carry commands, which a busy sequencer must ignore.
  task automatic run_command(input logic [2:0] cmd, input logic [ByteW-1:0] txb,
                             input logic ack, input sda_drive_e drive);
    send_tick(1'b1, cmd, txb, ack, sda_for(drive));
    while (seq_phase != PH_IDLE) begin
      send_tick(($urandom_range(3) == 0), 3'($urandom_range(7)), 8'($urandom),
                1'($urandom_range(1)), sda_for(drive));
    end
  endtask

  task automatic write_reg(input logic idx, input logic [TickW-1:0] val);
    in_valid = 1'b0;
    while (predicted_bus_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_idx = idx;
    cfg_wdata = val;
    cfg_we = 1'b1;
    if (idx == CfgUnitTicks) cfg_unit = val;
    else cfg_timeout = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  initial begin
    int phase_end;
    int roll;
    logic [2:0] cmd;
    plan = '{
      '{ROW_TICK, 1'b0, OP_START,    8'h00, 1'b0, SDA_HIGH, 1'b0, '0, 1'b1, IdleReleased},
      '{ROW_REG,  1'b0, OP_START,    8'h00, 1'b0, SDA_HIGH, CfgUnitTicks,  16'd1, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_START,    8'h00, 1'b0, SDA_COIN, 1'b0, '0, 1'b0, '0},
      '{ROW_TICK, 1'b1, OpRsvd5,     8'h00, 1'b0, SDA_LOW,  1'b0, '0, 1'b1, IdleBusLow},
      '{ROW_TICK, 1'b1, OpRsvd6,     8'hFF, 1'b1, SDA_HIGH, 1'b0, '0, 1'b1, IdleBusLow},
      '{ROW_TICK, 1'b1, OpRsvd7,     8'h5A, 1'b0, SDA_LOW,  1'b0, '0, 1'b1, IdleBusLow},
      '{ROW_REG,  1'b0, OP_START,    8'h00, 1'b0, SDA_HIGH, CfgAckTimeout, 16'd3, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_STOP,     8'h00, 1'b0, SDA_COIN, 1'b0, '0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_WRITE,    8'hFF, 1'b0, SDA_COIN, 1'b0, '0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_WRITE,    8'h00, 1'b1, SDA_COIN, 1'b0, '0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_WRITE,    8'hA5, 1'b0, SDA_COIN, 1'b0, '0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_READ,     8'h00, 1'b1, SDA_HIGH, 1'b0, '0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_READ,     8'hFF, 1'b0, SDA_LOW,  1'b0, '0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_READ,     8'h00, 1'b1, SDA_COIN, 1'b0, '0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_WAIT_ACK, 8'h00, 1'b0, SDA_LOW,  1'b0, '0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH, 1'b0, '0, 1'b0, '0},
      '{ROW_REG,  1'b0, OP_START,    8'h00, 1'b0, SDA_HIGH, CfgAckTimeout, 16'd0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH, 1'b0, '0, 1'b0, '0},
      '{ROW_REG,  1'b0, OP_START,    8'h00, 1'b0, SDA_HIGH, CfgUnitTicks,  16'd0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_START,    8'h00, 1'b0, SDA_COIN, 1'b0, '0, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_READ,     8'h00, 1'b0, SDA_COIN, 1'b0, '0, 1'b0, '0},
      '{ROW_REG,  1'b0, OP_START,    8'h00, 1'b0, SDA_HIGH, CfgUnitTicks,  16'hFFFF, 1'b0, '0},
      '{ROW_TICK, 1'b0, OP_WRITE,    8'h3C, 1'b1, SDA_LOW,  1'b0, '0, 1'b0, '0},
      '{ROW_TICK, 1'b1, OpRsvd7,     8'hC3, 1'b1, SDA_HIGH, 1'b0, '0, 1'b0, '0},
      '{ROW_REG,  1'b0, OP_START,    8'h00, 1'b0, SDA_HIGH, CfgAckTimeout, 16'hFFFF, 1'b0, '0},
      '{ROW_REG,  1'b0, OP_START,    8'h00, 1'b0, SDA_HIGH, CfgUnitTicks,  16'd1, 1'b0, '0},
      '{ROW_CMD,  1'b1, OP_WAIT_ACK, 8'h00, 1'b0, SDA_MOSTLY_HIGH, 1'b0, '0, 1'b0, '0}
    };
    reset_sequencer();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_REG: write_reg(plan[i].reg_idx, plan[i].reg_val);
        ROW_TICK: begin
          use_typed = plan[i].typed;
          typed_res = plan[i].want;
          send_tick(plan[i].cv, plan[i].op, plan[i].tx, plan[i].ack, sda_for(plan[i].sda));
        end
        default: run_command(plan[i].op, plan[i].tx, plan[i].ack, plan[i].sda);
      endcase
    end

    for (int s = 0; s < NumSettings; s++) begin
      write_reg(CfgUnitTicks, TickW'(unit_set[s]));
      write_reg(CfgAckTimeout, TickW'(tmo_set[s]));
      steady = (s % 3 == 2);
      // Let the result side stall for a long stretch while ticks keep coming.
      if (s == 1) hold_req = 1'b1;
      phase_end = ticks_sent + RandomTicks / NumSettings;
      while (ticks_sent < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 85) begin
          cmd = 3'($urandom_range(4));
          run_command(cmd, 8'($urandom), 1'($urandom_range(1)),
                      (cmd == OP_WAIT_ACK) ? SDA_MOSTLY_HIGH : SDA_COIN);
        end else if (roll < 93) begin
          send_tick(1'b0, 3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        end else begin
          send_tick(1'b1, 3'($urandom_range(7, 5)), 8'($urandom), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        end
      end
    end

    steady = 1'b0;
    in_valid = 1'b0;
    while (predicted_bus_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fault_count == 0 && predicted_bus_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
